FILE: rtl/core/trplru_pkg.sv
// Shared types and constants for the tree pseudo-LRU replacement engine.
`default_nettype none

package trplru_pkg;

    // Fixed field widths of one transaction
    localparam int unsigned CMD_W     = 1;
    localparam int unsigned SET_IDX_W = 6;
    localparam int unsigned WAY_IDX_W = 3;
    localparam int unsigned VICTIM_W  = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_VICTIM = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;   // zero one set of tree bits and advance the sweep
        logic load;    // capture the transaction and read its set
        logic walk;    // walk the tree, write it back, register the victim
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;   // the sweep is at the last set
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/core/trplru_ctrl.sv
// Sequencing controller: reset sweep, accept, tree walk and result strobe.
`default_nettype none

module trplru_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    output logic                o_valid,
    output trplru_pkg::t_dp_cmd o_cmd,
    input  trplru_pkg::t_dp_sts i_sts
);
    import trplru_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;
    logic       n_valid;

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                n_valid    = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Hold state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

FILE: rtl/core/trplru_dp.sv
// Datapath: tree-bit memory, clear sweep, tree walk and victim register.
`default_nettype none

module trplru_dp #(
    parameter int unsigned WAYS = 8,
    parameter int unsigned SETS = 64
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  trplru_pkg::t_dp_cmd                  i_cmd,
    output trplru_pkg::t_dp_sts                  o_sts,
    input  wire [trplru_pkg::CMD_W-1:0]          i_command,
    input  wire [trplru_pkg::SET_IDX_W-1:0]      i_set_index,
    input  wire [trplru_pkg::WAY_IDX_W-1:0]      i_way_index,
    output logic [trplru_pkg::VICTIM_W-1:0]      o_victim_way
);
    import trplru_pkg::*;

    localparam int unsigned NB     = WAYS - 1;                    // tree bits per set
    localparam int unsigned LEVELS = $clog2(WAYS);                // walk depth
    localparam int unsigned NW     = LEVELS + 1;                  // heap node width
    localparam int unsigned WW     = $clog2(WAYS + 1);            // way range width
    localparam int unsigned SW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned SET_N  = 1 << SET_IDX_W;

    // Tree-bit memory
    logic [NB-1:0] mem [SETS];

    logic [SW-1:0]        set_map [SET_N];
    logic [SW-1:0]        r_clr_cnt;
    logic [SW-1:0]        r_set;
    logic [CMD_W-1:0]     r_cmd;
    logic [WAY_IDX_W-1:0] r_way;
    logic [NB-1:0]        r_rd_data;
    logic [VICTIM_W-1:0]  r_victim;
    logic [NB-1:0]        walk_bits;
    logic [VICTIM_W-1:0]  walk_victim;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr;
    logic [NB-1:0]        wr_data;

    // Fold the set field into the available sets
    for (genvar g = 0; g < SET_N; g++) begin : g_set_map
        assign set_map[g] = SW'(g % SETS);
    end

    // Walk the tree from the root to a leaf
    always_comb begin
        logic [NB-1:0]       bits;
        logic [WW-1:0]       lo;
        logic [WW-1:0]       hi;
        logic [WW-1:0]       mid;
        logic [WW:0]         mid_sum;
        logic [NW-1:0]       node;
        logic                cur;
        logic                go_right;
        logic [WW+VICTIM_W-1:0] lo_ext;
        bits     = r_rd_data;
        lo       = '0;
        hi       = WW'(WAYS);
        node     = '0;
        mid      = '0;
        mid_sum  = '0;
        cur      = 1'b0;
        go_right = 1'b0;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            if ((hi - lo) > WW'(1)) begin
                mid_sum = {1'b0, lo} + {1'b0, hi};
                mid     = mid_sum[WW:1];
                cur     = 1'b0;
                for (int j = 0; j < NB; j++) begin
                    if (node == NW'(j)) begin
                        cur = bits[j];
                    end
                end
                if (r_cmd == CMD_VICTIM) begin
                    go_right = cur;
                end else begin
                    go_right = ((WW + WAY_IDX_W)'(r_way) >= (WW + WAY_IDX_W)'(mid));
                end
                // point the node away from the path taken
                for (int j = 0; j < NB; j++) begin
                    if (node == NW'(j)) begin
                        bits[j] = !go_right;
                    end
                end
                if (go_right) begin
                    lo   = mid;
                    node = NW'({node, 1'b0}) + NW'(2);
                end else begin
                    hi   = mid;
                    node = NW'({node, 1'b0}) + NW'(1);
                end
            end
        end
        lo_ext      = (WW + VICTIM_W)'(lo);
        walk_bits   = bits;
        walk_victim = (r_cmd == CMD_VICTIM) ? lo_ext[VICTIM_W-1:0] : '0;
    end

    // Select the write port: sweep or write-back
    always_comb begin
        wr_en   = i_cmd.clear | i_cmd.walk;
        wr_addr = i_cmd.clear ? r_clr_cnt : r_set;
        wr_data = i_cmd.clear ? '0 : walk_bits;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the addressed set on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= mem[set_map[i_set_index]];
        end
    end

    // Capture the transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set <= set_map[i_set_index];
            r_cmd <= i_command;
            r_way <= i_way_index;
        end
        if (i_cmd.walk) begin
            r_victim <= walk_victim;
        end
    end

    // Advance the clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear && !o_sts.clr_last) begin
            r_clr_cnt <= r_clr_cnt + SW'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == SW'(SETS - 1));
    assign o_victim_way   = r_victim;

endmodule

`default_nettype wire

FILE: rtl/core/tree_plru_replacement.sv
// Top level of the tree pseudo-LRU replacement engine.
//
//   channel  | handshake        | payload
//   ---------+------------------+----------------------------------------
//   command  | start / busy     | i_command, i_set_index, i_way_index
//   result   | o_valid (strobe) | o_victim_way
//
// A transaction is taken when start is high and busy is low; its result
// strobes from the result register after the walk state, one read-modify-write
// of the set's tree bits through a single-port memory with registered read;
// busy stays high through the walk, so a new transaction waits for it.
// After reset a sweep zeroes the tree bits, one set per cycle, with busy high.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module tree_plru_replacement #(
    parameter int unsigned WAYS = 8,
    parameter int unsigned SETS = 64
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire [trplru_pkg::CMD_W-1:0]          i_command,
    input  wire [trplru_pkg::SET_IDX_W-1:0]      i_set_index,
    input  wire [trplru_pkg::WAY_IDX_W-1:0]      i_way_index,
    output logic                                 o_valid,
    output logic [trplru_pkg::VICTIM_W-1:0]      o_victim_way
);
    import trplru_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequence the transaction
    trplru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // Hold tree bits and walk them
    trplru_dp #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_command    (i_command),
        .i_set_index  (i_set_index),
        .i_way_index  (i_way_index),
        .o_victim_way (o_victim_way)
    );

endmodule

`default_nettype wire

FILE: rtl/core/trplru_checker.sv
// Port-level checker for the replacement engine and its bind.
`default_nettype none

module trplru_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire [0:0] i_command,
    input wire       o_valid,
    input wire [2:0] o_victim_way
);

    // Busy rises right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not set after accepted transaction");

    // Each accepted transaction is followed by its result strobe
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result strobe missing two cycles after accept");

    // A touch reports way zero
    a_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == 1'b0)) |-> ##2 (o_victim_way == 3'd0))
        else $error("touch result is not zero");

    // The strobe lasts one cycle and follows a busy cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy) ##1 !o_valid)
        else $error("result strobe not a single cycle after busy");

endmodule

bind tree_plru_replacement trplru_checker u_trplru_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_command    (i_command),
    .o_valid      (o_valid),
    .o_victim_way (o_victim_way)
);

`default_nettype wire
